@@ hdl/assert_macros.svh @@
// Assertion macros used by the core RTL file of the seam cost map block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent check on an explicit clock, switched off while the reset is high.
`define SCC_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Same check on the block's own clock and reset.
`define SCC_ASSERT(label, prop, msg) `SCC_ASSERT_RST(label, clock, reset, prop, msg)
`endif

@@ hdl/scc_pkg.sv @@
// Package with the constants and types of the seam cost map block.
`default_nettype none
package scc_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = 11;
   localparam int HEIGHT_BITS = 16;
   localparam int COST_BITS   = 24;
   localparam int ENERGY_BITS = 8;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(1024);
   localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(768);
   localparam logic [WIDTH_BITS-1:0]  WIDTH_LIMIT  = WIDTH_BITS'(MAX_WIDTH);

   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_BITS'(1);

   localparam logic signed [1:0] STEP_LEFT  = 2'sb11;
   localparam logic signed [1:0] STEP_UP    = 2'sb00;
   localparam logic signed [1:0] STEP_RIGHT = 2'sb01;

   localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

   // Where the current pixel sits in the frame, and which neighbors it may use.
   typedef struct packed {
      logic [COL_BITS-1:0] col;
      logic                interior;
      logic                row_one;
      logic                use_left;
      logic                use_right;
   } pos_type;

endpackage
`default_nettype wire

@@ hdl/scc_position.sv @@
// Column and row counters that place each pixel transaction in the frame.
`default_nettype none
module scc_position (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               frame_start,
   input  wire logic [scc_pkg::WIDTH_BITS-1:0]     image_width,
   input  wire logic [scc_pkg::HEIGHT_BITS-1:0]    image_height,
   output scc_pkg::pos_type                        pos
);

   logic [scc_pkg::COL_BITS-1:0]    col_ff, col_in;
   logic [scc_pkg::HEIGHT_BITS-1:0] row_ff, row_in;
   logic [scc_pkg::COL_BITS-1:0]    col;
   logic [scc_pkg::HEIGHT_BITS-1:0] row;
   logic [scc_pkg::WIDTH_BITS-1:0]  width_eff;
   logic [scc_pkg::WIDTH_BITS-1:0]  col_ext;
   logic [scc_pkg::HEIGHT_BITS:0]   row_ext;

   always_comb begin
      width_eff = (image_width > scc_pkg::WIDTH_LIMIT) ? scc_pkg::WIDTH_LIMIT : image_width;
      col = frame_start ? '0 : col_ff;
      row = frame_start ? '0 : row_ff;
      col_ext = scc_pkg::WIDTH_BITS'(col);
      row_ext = (scc_pkg::HEIGHT_BITS + 1)'(row);

      pos.col       = col;
      pos.interior  = (row != '0) && (row_ext + 17'd2 <= {1'b0, image_height})
                      && (col != '0) && (col_ext + 11'd2 <= width_eff);
      pos.row_one   = (row == scc_pkg::HEIGHT_BITS'(1));
      pos.use_left  = (col != scc_pkg::COL_BITS'(1));
      pos.use_right = (col == scc_pkg::COL_BITS'(1)) || (col_ext + 11'd2 != width_eff);

      // Wrap to the next row after the last column, and to row zero after the last row.
      if (col_ext + 11'd1 >= width_eff) begin
         col_in = '0;
         row_in = (row_ext + 17'd1 >= {1'b0, image_height}) ? '0 : row + 16'd1;
      end else begin
         col_in = col + 10'd1;
         row_in = row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/seam_cumulative_cost_map_core.sv @@
// Top level of the vertical seam cumulative cost map for an energy image stream.
// Energy pixels enter in raster order on the req_ channel, one transaction per
// pixel; req_frame_start marks row 0, column 0 of a frame. Every pixel gives one
// rsp_ transaction: the cumulative seam cost, the step to the cheapest upper
// neighbor (-1, 0, +1) and an interior flag. Border rows and columns give zeros.
// One pixel per cycle is accepted while rsp_ready stays high. The edge that
// accepts a request loads the input register and the line store read; once the
// result register is free, it takes the cost logic output and rsp_valid rises.
// The line store keeps one row of costs and has a single write and a single
// read port; it needs no clearing pass, since each row is written before the
// next row reads it.
// When the receiver stalls, the result register holds and the input register
// can still take one more pixel; req_ready then drops until the result moves.
// Reset empties the pipeline, clears the counters and restores image_width to
// 1024 and image_height to 768. Configuration is written through csr_ while
// the block is idle. The block does not enforce this; the user must.
`default_nettype none
`include "assert_macros.svh"
module seam_cumulative_cost_map_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [scc_pkg::ENERGY_BITS-1:0]      req_energy,
   input  wire logic                                 req_frame_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [scc_pkg::COST_BITS-1:0]             rsp_seam_cost,
   output logic signed [1:0]                         rsp_step,
   output logic                                      rsp_interior,
   input  wire logic                                 csr_write_en,
   input  wire logic [scc_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [scc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   logic [scc_pkg::WIDTH_BITS-1:0]  width_ff;
   logic [scc_pkg::HEIGHT_BITS-1:0] height_ff;

   logic [scc_pkg::COST_BITS-1:0] cost_line_ff [scc_pkg::MAX_WIDTH];
   logic [scc_pkg::COST_BITS-1:0] right_ff;
   logic [scc_pkg::COST_BITS-1:0] above_ff;
   logic [scc_pkg::COST_BITS-1:0] left_ff;
   logic [scc_pkg::COL_BITS-1:0]  rd_addr;

   logic                            s1_valid_ff, s1_valid_in;
   logic [scc_pkg::ENERGY_BITS-1:0] s1_energy_ff;
   scc_pkg::pos_type                s1_pos_ff;
   scc_pkg::pos_type                pos;

   logic                          out_valid_ff, out_valid_in;
   logic [scc_pkg::COST_BITS-1:0] out_cost_ff;
   logic signed [1:0]             out_step_ff;
   logic                          out_interior_ff;

   logic                          accept;
   logic                          out_free;
   logic                          s1_advance;
   logic [scc_pkg::COST_BITS-1:0] best;
   logic signed [1:0]             step_sel;
   logic [scc_pkg::COST_BITS:0]   sum;
   logic [scc_pkg::COST_BITS-1:0] cost_in;
   logic signed [1:0]             step_in;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= scc_pkg::WIDTH_RESET;
         height_ff <= scc_pkg::HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            scc_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[scc_pkg::WIDTH_BITS-1:0];
            end
            scc_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_free   = !out_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || out_free;
   assign accept     = req_valid && req_ready;

   scc_position u_position (
      .clock        (clock),
      .reset        (reset),
      .advance      (accept),
      .frame_start  (req_frame_start),
      .image_width  (width_ff),
      .image_height (height_ff),
      .pos          (pos)
   );

   // The right neighbor of column c is the entry at c+1, which this row has not
   // written yet. The same read, one pixel later, is the value above.
   assign rd_addr = pos.col + 10'd1;

   always_ff @(posedge clock) begin
      if (accept) begin
         right_ff <= cost_line_ff[rd_addr];
      end
      if (s1_advance) begin
         cost_line_ff[s1_pos_ff.col] <= cost_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_energy_ff <= req_energy;
         s1_pos_ff    <= pos;
      end
      if (s1_advance) begin
         above_ff <= right_ff;
         left_ff  <= above_ff;
      end
   end

   // Minimum of three with ties going left, then up, then right.
   always_comb begin
      best     = above_ff;
      step_sel = scc_pkg::STEP_UP;
      if (s1_pos_ff.use_left && (left_ff <= best)) begin
         best     = left_ff;
         step_sel = scc_pkg::STEP_LEFT;
      end
      if (s1_pos_ff.use_right && (right_ff < best)) begin
         best     = right_ff;
         step_sel = scc_pkg::STEP_RIGHT;
      end
      sum = {1'b0, best} + (scc_pkg::COST_BITS + 1)'(s1_energy_ff);

      if (!s1_pos_ff.interior) begin
         cost_in = '0;
         step_in = scc_pkg::STEP_UP;
      end else if (s1_pos_ff.row_one) begin
         cost_in = scc_pkg::COST_BITS'(s1_energy_ff);
         step_in = scc_pkg::STEP_UP;
      end else begin
         cost_in = sum[scc_pkg::COST_BITS] ? scc_pkg::COST_MAX : sum[scc_pkg::COST_BITS-1:0];
         step_in = step_sel;
      end
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_cost_ff     <= cost_in;
         out_step_ff     <= step_in;
         out_interior_ff <= s1_pos_ff.interior;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_seam_cost = out_cost_ff;
   assign rsp_step      = out_step_ff;
   assign rsp_interior  = out_interior_ff;

   `SCC_ASSERT(a_border_zero, (out_valid_ff && !out_interior_ff) |-> ((out_cost_ff == '0) && (out_step_ff == scc_pkg::STEP_UP)), "border pixel result is not zero")
   `SCC_ASSERT(a_step_code, out_valid_ff |-> (out_step_ff != 2'sb10), "step code out of range")
   `SCC_ASSERT(a_row_one_cost, (s1_valid_ff && s1_pos_ff.interior && s1_pos_ff.row_one) |-> (cost_in == scc_pkg::COST_BITS'(s1_energy_ff)), "row one cost differs from energy")
   `SCC_ASSERT(a_result_load, s1_advance |=> out_valid_ff, "advanced pixel did not reach the result register")

endmodule
`default_nettype wire

@@ dv/tb_seam_cumulative_cost_map_core.sv @@
// Self-checking testbench for the seam cumulative cost map core.
`timescale 1ns / 1ps
module tb_seam_cumulative_cost_map_core;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 40;
   localparam int RANDOM_PIXELS = 470;
   // Index with no register behind it; a write there must change nothing.
   localparam logic [scc_pkg::CSR_IDX_BITS-1:0] CSR_SPARE = scc_pkg::CSR_IDX_BITS'(3);

   typedef struct packed {
      logic [scc_pkg::ENERGY_BITS-1:0] energy;
      logic                            frame_start;
   } pixel_type;

   typedef struct packed {
      logic [scc_pkg::COST_BITS-1:0] seam_cost;
      logic signed [1:0]             step;
      logic                          interior;
   } seam_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [scc_pkg::ENERGY_BITS-1:0] req_energy = '0;
   logic req_frame_start = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [scc_pkg::COST_BITS-1:0] rsp_seam_cost;
   logic signed [1:0] rsp_step;
   logic rsp_interior;
   logic csr_write_en = 1'b0;
   logic [scc_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [scc_pkg::CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Shadow copy of the block's configuration and state.
   logic [scc_pkg::COST_BITS-1:0] line_costs [scc_pkg::MAX_WIDTH];
   logic [scc_pkg::COST_BITS-1:0] held_left;
   int unsigned shadow_col;
   int unsigned shadow_row;
   int unsigned shadow_width;
   int unsigned shadow_height;

   pixel_type pixel_queue [$];
   seam_result_type pending_costs [$];
   seam_result_type seam_want;
   seam_result_type seam_pred;
   int queued_count = 0;
   int accepted_count = 0;
   int result_count = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   logic req_taken = 1'b0;
   logic no_gaps = 1'b0;

   seam_cumulative_cost_map_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_energy      (req_energy),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seam_cost   (rsp_seam_cost),
      .rsp_step        (rsp_step),
      .rsp_interior    (rsp_interior),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the cost, step and interior flag of one pixel and advances the
   // shadow counters and line store.
   function automatic seam_result_type next_seam_cost(input pixel_type pix);
      int unsigned eff_width;
      int unsigned col;
      int unsigned row;
      logic [scc_pkg::COST_BITS-1:0] above;
      logic [scc_pkg::COST_BITS-1:0] right_cost;
      logic [scc_pkg::COST_BITS-1:0] best;
      logic [scc_pkg::COST_BITS:0] sum;
      logic left_ok;
      logic right_ok;
      seam_result_type res;
      eff_width = (shadow_width > scc_pkg::MAX_WIDTH) ? scc_pkg::MAX_WIDTH : shadow_width;
      if (pix.frame_start) begin
         shadow_col = 0;
         shadow_row = 0;
      end
      col = shadow_col;
      row = shadow_row;
      res = '0;
      res.step = scc_pkg::STEP_UP;
      res.interior = row >= 1 && row + 2 <= shadow_height && col >= 1 && col + 2 <= eff_width;
      above = line_costs[col];
      right_cost = (col + 1 < scc_pkg::MAX_WIDTH) ? line_costs[col + 1] : '0;
      if (res.interior) begin
         best = '0;
         if (row != 1) begin
            left_ok = col != 1;
            right_ok = (col == 1) || (col + 2 != eff_width);
            best = above;
            if (left_ok && held_left <= best) begin
               best = held_left;
               res.step = scc_pkg::STEP_LEFT;
            end
            if (right_ok && right_cost < best) begin
               best = right_cost;
               res.step = scc_pkg::STEP_RIGHT;
            end
         end
         sum = {1'b0, best} + pix.energy;
         res.seam_cost = sum[scc_pkg::COST_BITS] ? scc_pkg::COST_MAX
                                                 : sum[scc_pkg::COST_BITS-1:0];
      end
      line_costs[col] = res.seam_cost;
      held_left = above;
      if (col + 1 >= eff_width) begin
         shadow_col = 0;
         shadow_row = (row + 1 >= shadow_height) ? 0 : row + 1;
      end else begin
         shadow_col = col + 1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endtask

   function automatic logic [scc_pkg::ENERGY_BITS-1:0] pick_energy();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         // Small values make ties between neighbors common.
         2, 3, 4, 5: return scc_pkg::ENERGY_BITS'($urandom_range(3));
         default: return scc_pkg::ENERGY_BITS'($urandom_range(255));
      endcase
   endfunction

   task automatic push_pixel(input logic [scc_pkg::ENERGY_BITS-1:0] energy,
                             input logic frame_start);
      pixel_type pix;
      pix.energy = energy;
      pix.frame_start = frame_start;
      pixel_queue.push_back(pix);
      queued_count++;
   endtask

   // A run of pixels; frame_start may also show up mid-frame as noise.
   task automatic queue_pixels(input int count, input logic restart, input int noise_pct);
      for (int i = 0; i < count; i++) begin
         push_pixel(pick_energy(), (i == 0) ? restart : ($urandom_range(99) < noise_pct));
      end
   endtask

   task automatic wait_idle();
      while (accepted_count != queued_count || pending_costs.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [scc_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [scc_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         scc_pkg::CSR_IMAGE_WIDTH: shadow_width = data[scc_pkg::WIDTH_BITS-1:0];
         scc_pkg::CSR_IMAGE_HEIGHT: shadow_height = data[scc_pkg::HEIGHT_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_geometry(input int unsigned w, input int unsigned h);
      write_csr(scc_pkg::CSR_IMAGE_WIDTH, scc_pkg::CSR_DATA_BITS'(w));
      write_csr(scc_pkg::CSR_IMAGE_HEIGHT, scc_pkg::CSR_DATA_BITS'(h));
   endtask

   // Driver: presents the next pixel once the previous one has been taken.
   always @(negedge clock) begin
      pixel_type pix;
      rsp_ready <= no_gaps || ($urandom_range(99) >= 15);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() > 0 && (no_gaps || $urandom_range(99) >= 15)) begin
            pix = pixel_queue.pop_front();
            req_valid <= 1'b1;
            req_energy <= pix.energy;
            req_frame_start <= pix.frame_start;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts on each accepted pixel and checks each result transaction.
   always @(posedge clock) begin
      pixel_type pix;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pix.energy = req_energy;
            pix.frame_start = req_frame_start;
            seam_pred = next_seam_cost(pix);
            pending_costs.push_back(seam_pred);
            accepted_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_costs.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending, cost %0d",
                                         rsp_seam_cost));
            end else begin
               seam_want = pending_costs.pop_front();
               if (rsp_seam_cost !== seam_want.seam_cost)
                  report_mismatch($sformatf("pixel %0d cost %0d, expected %0d",
                                            result_count, rsp_seam_cost, seam_want.seam_cost));
               if (rsp_step !== seam_want.step)
                  report_mismatch($sformatf("pixel %0d step %0d, expected %0d",
                                            result_count, rsp_step, seam_want.step));
               if (rsp_interior !== seam_want.interior)
                  report_mismatch($sformatf("pixel %0d interior %0b, expected %0b",
                                            result_count, rsp_interior, seam_want.interior));
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int unsigned w;
      int unsigned h;
      int unsigned wm;
      int unsigned old_w;
      int count;
      int random_pixels;
      shadow_width = scc_pkg::WIDTH_RESET;
      shadow_height = scc_pkg::HEIGHT_RESET;
      shadow_col = 0;
      shadow_row = 0;
      held_left = '0;
      random_pixels = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest useful frame, with ties on both interior columns.
      set_geometry(4, 4);
      push_pixel(8'd0, 1'b1);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd7, 1'b0);
      push_pixel(8'd7, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd1, 1'b0);
      push_pixel(8'd2, 1'b0);
      push_pixel(8'd3, 1'b0);
      push_pixel(8'd4, 1'b0);
      // A frame start in the middle of a row restarts the counters.
      push_pixel(8'd9, 1'b1);
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd9, 1'b1);
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd9, 1'b0);
      push_pixel(8'd9, 1'b0);
      wait_idle();

      // Degenerate geometries: nothing is interior.
      set_geometry(0, 0);
      queue_pixels(12, 1'b1, 5);
      wait_idle();
      set_geometry(1, 1);
      queue_pixels(12, 1'b0, 5);
      wait_idle();
      set_geometry(3, 2);
      queue_pixels(14, 1'b1, 0);
      wait_idle();
      write_csr(CSR_SPARE, scc_pkg::CSR_DATA_BITS'($urandom_range(16'hFFFF)));
      set_geometry(2, 16'hFFFF);
      queue_pixels(16, 1'b1, 0);
      wait_idle();

      // Width beyond the line store: one short row reaches row one, then the
      // width grows. Row one costs never read the line store, so the wider row
      // is safe; a width truncated to the column bits would wrap early.
      no_gaps = 1'b1;
      set_geometry(4, 8);
      queue_pixels(4, 1'b1, 0);
      wait_idle();
      write_csr(scc_pkg::CSR_IMAGE_WIDTH, scc_pkg::CSR_DATA_BITS'(1030));
      queue_pixels(40, 1'b0, 0);
      wait_idle();
      no_gaps = 1'b0;

      set_geometry(4, 16'hFFFF);
      queue_pixels(60, 1'b1, 0);
      wait_idle();

      while (random_pixels < RANDOM_PIXELS) begin
         case ($urandom_range(19))
            0: begin
               w = $urandom_range(0, 3);
               h = $urandom_range(3, 8);
            end
            1: begin
               w = $urandom_range(4, 10);
               h = $urandom_range(0, 2);
            end
            2: begin
               w = $urandom_range(17, 80);
               h = $urandom_range(3, 6);
            end
            default: begin
               w = $urandom_range(4, 16);
               h = $urandom_range(3, 12);
            end
         endcase
         old_w = shadow_width;
         if ($urandom_range(3) != 0) write_csr(scc_pkg::CSR_IMAGE_WIDTH, scc_pkg::CSR_DATA_BITS'(w));
         if ($urandom_range(3) != 0) write_csr(scc_pkg::CSR_IMAGE_HEIGHT, scc_pkg::CSR_DATA_BITS'(h));
         wm = (shadow_width > scc_pkg::MAX_WIDTH) ? scc_pkg::MAX_WIDTH : shadow_width;
         if (wm == 0) wm = 1;
         count = wm * ((shadow_height == 0) ? 1 : shadow_height) + $urandom_range(8);
         if (count > 150) count = 150;
         // A wider row would read line store entries that this frame never wrote.
         queue_pixels(count, (shadow_width > old_w) || ($urandom_range(4) != 0), 2);
         random_pixels += count;
         wait_idle();
      end

      repeat (5) @(negedge clock);
      if (pending_costs.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", pending_costs.size()));
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
